FILE: design/dtba_pkg.sv
`default_nettype none

package dtba_pkg;

	// Field widths
	localparam int TS_W    = 64;
	localparam int LEN_W   = 16;
	localparam int MBPS_W  = 17;
	localparam int LVL_W   = 35;
	localparam int DEPTH_W = 34;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 17;

	// Default parameter values
	localparam int REFILL_SHIFT_DEF   = 6;
	localparam int BUCKET_SECONDS_DEF = 1;

	// Rate and time constants
	localparam longint unsigned NS_PER_S       = 64'd1000000000;
	localparam longint unsigned RATE_CAP       = 64'd100000;
	localparam longint unsigned BYTES_PER_MBPS = 64'd125000;
	localparam longint unsigned MAX_BPS        = RATE_CAP * BYTES_PER_MBPS;
	localparam logic [DEPTH_W-1:0] DEPTH_CAP   = {DEPTH_W{1'b1}};

	// One byte at 1 Mbit/s lasts 8000 ns = 64 * 125 ns
	localparam longint unsigned NS_PER_BYTE_MBPS = 64'd8000;
	localparam int DIV_SHIFT = 6;

	// Reciprocals of 125, exact for the operand ranges used in the refill pipe
	localparam int RECIP_A_W     = 27;
	localparam int RECIP_A_SHIFT = 33;
	localparam logic [RECIP_A_W-1:0] RECIP_A = 27'd68719477;
	localparam int RECIP_B_W     = 25;
	localparam int RECIP_B_SHIFT = 31;
	localparam logic [RECIP_B_W-1:0] RECIP_B = 25'd17179870;

	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GUARANTEED = 8'd0,
		REG_CEILING    = 8'd1,
		REG_HIGH_UNLIM = 8'd2,
		REG_LOW_UNLIM  = 8'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		POOL_NONE = 2'd0,
		POOL_LOW  = 2'd1,
		POOL_HIGH = 2'd2,
		POOL_DEBT = 2'd3
	} pool_t;

endpackage

`default_nettype wire

FILE: design/dtba_refill.sv
`default_nettype none

// Three-stage refill pipe: elapsed time check, then mbps * elapsed / 8000
// split into quotient and remainder parts, each divided by a shift and a reciprocal multiply.
module dtba_refill #(
	parameter int REFILL_SHIFT   = dtba_pkg::REFILL_SHIFT_DEF,
	parameter int BUCKET_SECONDS = dtba_pkg::BUCKET_SECONDS_DEF,
	parameter int ADD_W          = 34
) (
	input  wire logic                          clk,
	input  wire logic                          adv,
	input  wire logic [dtba_pkg::TS_W-1:0]     now,
	input  wire logic [dtba_pkg::TS_W-1:0]     last,
	input  wire logic                          blank,
	input  wire logic [dtba_pkg::MBPS_W-1:0]   mbps,
	output logic                               early_hit,
	output logic                               hit,
	output logic [ADD_W-1:0]                   amount
);

	localparam longint unsigned MAX_TICKS = longint'(BUCKET_SECONDS) * dtba_pkg::NS_PER_S;
	localparam longint unsigned THRESHOLD = MAX_TICKS >> REFILL_SHIFT;
	localparam int EL_W = $clog2(MAX_TICKS + 1);
	localparam int N_W  = EL_W - dtba_pkg::DIV_SHIFT;
	localparam int Q_W  = $clog2(MAX_TICKS / dtba_pkg::NS_PER_BYTE_MBPS + 1);
	localparam int R_W  = $clog2(dtba_pkg::NS_PER_BYTE_MBPS);
	localparam int PA_W = N_W + dtba_pkg::RECIP_A_W;
	localparam int PQ_W = dtba_pkg::MBPS_W + Q_W;
	localparam int PR_W = dtba_pkg::MBPS_W + R_W;
	localparam int M_W  = PR_W - dtba_pkg::DIV_SHIFT;
	localparam int PB_W = M_W + dtba_pkg::RECIP_B_W;

	logic [dtba_pkg::TS_W-1:0] el;
	logic [EL_W-1:0]           el_c;
	logic [PA_W-1:0]           prod_a;
	logic [Q_W-1:0]            q;
	logic [EL_W-1:0]           r_full;
	logic [PB_W-1:0]           prod_b;
	logic [PQ_W:0]             sum;

	logic                      hit_s2, hit_s3;
	logic [Q_W-1:0]            q_s2;
	logic [R_W-1:0]            r_s2;
	logic [PQ_W-1:0]           pq_s3;
	logic [PR_W-1:0]           pr_s3;

	// Elapsed time, refill qualification and cap
	always_comb begin
		el        = now - last;
		early_hit = !el[dtba_pkg::TS_W-1] && (el > THRESHOLD) && !blank;
		el_c      = (el > MAX_TICKS) ? EL_W'(MAX_TICKS) : el[EL_W-1:0];
		prod_a    = PA_W'(el_c[EL_W-1:dtba_pkg::DIV_SHIFT]) * PA_W'(dtba_pkg::RECIP_A);
		q         = prod_a[dtba_pkg::RECIP_A_SHIFT +: Q_W];
		r_full    = el_c - EL_W'(q) * EL_W'(dtba_pkg::NS_PER_BYTE_MBPS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s2 <= early_hit;
			q_s2   <= q;
			r_s2   <= r_full[R_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s3 <= hit_s2;
			pq_s3  <= PQ_W'(mbps) * PQ_W'(q_s2);
			pr_s3  <= PR_W'(mbps) * PR_W'(r_s2);
		end
	end

	always_comb begin
		prod_b = PB_W'(pr_s3[PR_W-1:dtba_pkg::DIV_SHIFT]) * PB_W'(dtba_pkg::RECIP_B);
		sum    = (PQ_W+1)'(pq_s3) + (PQ_W+1)'(prod_b[dtba_pkg::RECIP_B_SHIFT +: dtba_pkg::MBPS_W]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit    <= hit_s3;
			amount <= sum[ADD_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: design/dual_token_bucket_admission_top.sv
`default_nettype none

// Two-pool token bucket admission. Each packet beat (timestamp, length, priority,
// class flag) yields one result beat: accept, the pool charged and both pool
// levels after the packet. One packet beat is taken every clock cycle while the
// pipe advances; a result passes the stages, then waits in the output register
// until taken, while the pipe keeps filling behind it. The refill amount (rate *
// elapsed / 1e9) runs through a three-stage multiply pipe; the token levels are
// read, refilled, charged and written back in the single decision stage, so the
// level feedback loop closes within that stage. Because an item in the decision
// stage may or may not refill the high pool, the high pool runs four refill pipes
// in parallel, one per possible last-refill time (the stored one or that of any
// of the three packets ahead), and the decision stage picks the right one.
// Software must write rates only while the block is idle; the block does not
// enforce it. A rate change clamps the levels to the new depths, and the next
// packet restarts both refill clocks from its own timestamp.
module dual_token_bucket_admission_top #(
	parameter int REFILL_SHIFT   = dtba_pkg::REFILL_SHIFT_DEF,
	parameter int BUCKET_SECONDS = dtba_pkg::BUCKET_SECONDS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// packet channel
	input  wire logic                                pkt_valid,
	output logic                                     pkt_ready,
	input  wire logic [dtba_pkg::TS_W-1:0]           timestamp_ns,
	input  wire logic [dtba_pkg::LEN_W-1:0]          packet_length,
	input  wire logic                                high_priority,
	input  wire logic                                in_class,
	// result channel
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic                                     accept,
	output logic [1:0]                               charged_pool,
	output logic signed [dtba_pkg::LVL_W-1:0]        low_level,
	output logic signed [dtba_pkg::LVL_W-1:0]        high_level,
	// configuration channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [dtba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dtba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int LVL_W   = dtba_pkg::LVL_W;
	localparam int DEPTH_W = dtba_pkg::DEPTH_W;
	localparam int ADD_W   = $clog2(dtba_pkg::MAX_BPS * longint'(BUCKET_SECONDS) + 1);
	localparam int SUM_W   = ((ADD_W > LVL_W) ? ADD_W : LVL_W) + 2;
	localparam int NCAND   = 4;
	localparam logic [ADD_W-1:0] BPS_SCALE =
		ADD_W'(dtba_pkg::BYTES_PER_MBPS * longint'(BUCKET_SECONDS));

	// Saturate to depth in both directions
	function automatic logic signed [LVL_W-1:0] clamp_lvl(
		input logic signed [SUM_W-1:0] v,
		input logic [DEPTH_W-1:0]      d
	);
		logic signed [SUM_W-1:0] ds;
		ds = $signed(SUM_W'(d));
		if (v > ds)
			return LVL_W'(ds);
		else if (v < -ds)
			return LVL_W'(-ds);
		else
			return LVL_W'(v);
	endfunction

	// ---------------------------------------------------------------- config
	logic [dtba_pkg::MBPS_W-1:0] guar_q, ceil_q, hi_mbps, cfg_sat;
	logic                        high_unl_q, low_unl_q, restart_q;
	logic [DEPTH_W-1:0]          lo_depth_q, hi_depth_q;
	logic [ADD_W-1:0]            lo_draw, hi_draw;
	logic                        pkt_take;

	assign cfg_ready = 1'b1;
	assign cfg_sat   = (cfg_data > dtba_pkg::CFG_DATA_W'(dtba_pkg::RATE_CAP))
		? dtba_pkg::MBPS_W'(dtba_pkg::RATE_CAP) : cfg_data;
	assign hi_mbps   = (ceil_q > guar_q) ? ceil_q - guar_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guar_q     <= '0;
			ceil_q     <= dtba_pkg::MBPS_W'(1000);
			high_unl_q <= 1'b0;
			low_unl_q  <= 1'b0;
			restart_q  <= 1'b1;
		end else begin
			// the first packet after a restart clears the flag
			if (pkt_take)
				restart_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (dtba_pkg::cfg_reg_t'(cfg_index))
					dtba_pkg::REG_GUARANTEED: begin
						if (cfg_sat != guar_q) begin
							guar_q    <= cfg_sat;
							restart_q <= 1'b1;
						end
					end
					dtba_pkg::REG_CEILING: begin
						if (cfg_sat != ceil_q) begin
							ceil_q    <= cfg_sat;
							restart_q <= 1'b1;
						end
					end
					dtba_pkg::REG_HIGH_UNLIM: high_unl_q <= cfg_data[0];
					dtba_pkg::REG_LOW_UNLIM:  low_unl_q  <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// Depth = one bucket time of byte rate, saturated to fit the level width
	always_comb begin
		lo_draw = ADD_W'(guar_q) * BPS_SCALE;
		hi_draw = ADD_W'(hi_mbps) * BPS_SCALE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_depth_q <= '0;
			hi_depth_q <= '0;
		end else begin
			lo_depth_q <= (lo_draw > ADD_W'(dtba_pkg::DEPTH_CAP)) ? dtba_pkg::DEPTH_CAP
				: lo_draw[DEPTH_W-1:0];
			hi_depth_q <= (hi_draw > ADD_W'(dtba_pkg::DEPTH_CAP)) ? dtba_pkg::DEPTH_CAP
				: hi_draw[DEPTH_W-1:0];
		end
	end

	// ---------------------------------------------------------------- pipe
	logic v_s1, v_s2, v_s3, v_s4, adv;
	logic [dtba_pkg::TS_W-1:0]  ts_s1, ts_s2, ts_s3, ts_s4;
	logic [dtba_pkg::LEN_W-1:0] len_s1, len_s2, len_s3, len_s4;
	logic hp_s1, hp_s2, hp_s3, hp_s4;
	logic ic_s2, ic_s3, ic_s4, ic_s1;
	logic rs_s1, rs_s2, rs_s3, rs_s4;
	logic byp_s2, byp_s3, byp_s4;
	logic la_s2, la_s3, la_s4;
	logic byp_s1, la_s1;

	// The whole pipe advances together; hold only when a result sits in the
	// decision stage and the output register cannot take it.
	assign adv       = !v_s4 || !res_valid || res_ready;
	assign pkt_ready = adv;
	assign pkt_take  = pkt_valid && pkt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pkt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			ts_s1  <= timestamp_ns;
			len_s1 <= packet_length;
			hp_s1  <= high_priority;
			ic_s1  <= in_class;
			rs_s1  <= restart_q;
		end
		if (adv) begin
			ts_s2  <= ts_s1;  ts_s3  <= ts_s2;  ts_s4  <= ts_s3;
			len_s2 <= len_s1; len_s3 <= len_s2; len_s4 <= len_s3;
			hp_s2  <= hp_s1;  hp_s3  <= hp_s2;  hp_s4  <= hp_s3;
			ic_s2  <= ic_s1;  ic_s3  <= ic_s2;  ic_s4  <= ic_s3;
			rs_s2  <= rs_s1;  rs_s3  <= rs_s2;  rs_s4  <= rs_s3;
			byp_s2 <= byp_s1; byp_s3 <= byp_s2; byp_s4 <= byp_s3;
			la_s2  <= la_s1;  la_s3  <= la_s2;  la_s4  <= la_s3;
		end
	end

	// Oversize bypass and whether the low pool refills are known up front
	assign byp_s1 = DEPTH_W'(len_s1) > lo_depth_q;
	assign la_s1  = ic_s1 && !byp_s1 && (hp_s1 ? !high_unl_q : !low_unl_q);

	// ---------------------------------------------------------------- low refill
	logic [dtba_pkg::TS_W-1:0] lo_last_q;
	logic                      lo_early, lo_hit;
	logic [ADD_W-1:0]          lo_amt;

	dtba_refill #(
		.REFILL_SHIFT   (REFILL_SHIFT),
		.BUCKET_SECONDS (BUCKET_SECONDS),
		.ADD_W          (ADD_W)
	) u_lo_refill (
		.clk       (clk),
		.adv       (adv),
		.now       (ts_s1),
		.last      (lo_last_q),
		.blank     (rs_s1),
		.mbps      (guar_q),
		.early_hit (lo_early),
		.hit       (lo_hit),
		.amount    (lo_amt)
	);

	// The low pool's refill clock does not depend on levels: advance it here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lo_last_q <= '0;
		else if (adv && v_s1 && (rs_s1 || (la_s1 && lo_early)))
			lo_last_q <= ts_s1;
	end

	// ---------------------------------------------------------------- high refill
	logic [dtba_pkg::TS_W-1:0] hi_last_q;
	logic [dtba_pkg::TS_W-1:0] cand_last [NCAND];
	logic                      cand_hit  [NCAND];
	logic [ADD_W-1:0]          cand_amt  [NCAND];
	logic                      upd_h1, upd_h2, upd_h3;
	logic                      hi_hit;
	logic [ADD_W-1:0]          hi_amt;

	// candidate 0: stored refill time; 1..3: the packets in stages 4, 3 and 2
	assign cand_last[0] = hi_last_q;
	assign cand_last[1] = ts_s4;
	assign cand_last[2] = ts_s3;
	assign cand_last[3] = ts_s2;

	for (genvar c = 0; c < NCAND; c++) begin : g_hi
		dtba_refill #(
			.REFILL_SHIFT   (REFILL_SHIFT),
			.BUCKET_SECONDS (BUCKET_SECONDS),
			.ADD_W          (ADD_W)
		) u_hi_refill (
			.clk       (clk),
			.adv       (adv),
			.now       (ts_s1),
			.last      (cand_last[c]),
			.blank     (rs_s1),
			.mbps      (hi_mbps),
			.early_hit (),
			.hit       (cand_hit[c]),
			.amount    (cand_amt[c])
		);
	end

	// Pick the pipe whose last time matches the most recent high refill ahead
	always_comb begin
		if (upd_h1) begin
			hi_hit = cand_hit[3];
			hi_amt = cand_amt[3];
		end else if (upd_h2) begin
			hi_hit = cand_hit[2];
			hi_amt = cand_amt[2];
		end else if (upd_h3) begin
			hi_hit = cand_hit[1];
			hi_amt = cand_amt[1];
		end else begin
			hi_hit = cand_hit[0];
			hi_amt = cand_amt[0];
		end
	end

	// ---------------------------------------------------------------- decision
	logic signed [LVL_W-1:0] lo_tok_q, hi_tok_q;
	logic signed [LVL_W-1:0] lo_ref, hi_ref, lo_nxt, hi_nxt, len_l;
	logic signed [LVL_W:0]   lo_room, hi_room, len_x;
	logic signed [SUM_W-1:0] lo_sum, hi_sum;
	logic                    acc_nxt, hi_apply, upd_now;
	dtba_pkg::pool_t         pool_nxt;

	always_comb begin
		lo_sum = $signed({{(SUM_W-LVL_W){lo_tok_q[LVL_W-1]}}, lo_tok_q})
			+ $signed(SUM_W'(lo_amt));
		hi_sum = $signed({{(SUM_W-LVL_W){hi_tok_q[LVL_W-1]}}, hi_tok_q})
			+ $signed(SUM_W'(hi_amt));
		lo_ref  = (la_s4 && lo_hit) ? clamp_lvl(lo_sum, lo_depth_q) : lo_tok_q;
		hi_ref  = hi_hit ? clamp_lvl(hi_sum, hi_depth_q) : hi_tok_q;
		len_l   = $signed(LVL_W'(len_s4));
		len_x   = $signed((LVL_W+1)'(len_s4));
		lo_room = $signed({lo_ref[LVL_W-1], lo_ref}) + $signed((LVL_W+1)'(lo_depth_q));
		hi_room = $signed({hi_ref[LVL_W-1], hi_ref}) + $signed((LVL_W+1)'(hi_depth_q));

		acc_nxt  = 1'b1;
		pool_nxt = dtba_pkg::POOL_NONE;
		lo_nxt   = lo_tok_q;
		hi_nxt   = hi_tok_q;
		hi_apply = 1'b0;

		if (ic_s4 && !byp_s4) begin
			if (hp_s4) begin
				if (!high_unl_q) begin
					// low pool first, then high, else run the high pool into debt
					lo_nxt = lo_ref;
					if (lo_ref > len_l) begin
						lo_nxt   = lo_ref - len_l;
						pool_nxt = dtba_pkg::POOL_LOW;
					end else begin
						hi_apply = 1'b1;
						if (hi_ref > len_l) begin
							hi_nxt   = hi_ref - len_l;
							pool_nxt = dtba_pkg::POOL_HIGH;
						end else begin
							hi_nxt   = (hi_room < len_x) ? -$signed(LVL_W'(hi_depth_q))
								: hi_ref - len_l;
							pool_nxt = dtba_pkg::POOL_DEBT;
						end
					end
				end
			end else if (!low_unl_q) begin
				// high pool first, then borrow from low, else drop
				hi_apply = 1'b1;
				lo_nxt   = lo_ref;
				hi_nxt   = hi_ref;
				if (hi_ref > len_l) begin
					hi_nxt   = hi_ref - len_l;
					pool_nxt = dtba_pkg::POOL_HIGH;
				end else if (lo_room > len_x) begin
					lo_nxt   = lo_ref - len_l;
					pool_nxt = dtba_pkg::POOL_LOW;
				end else begin
					acc_nxt = 1'b0;
				end
			end
		end

		upd_now = v_s4 && (rs_s4 || (hi_apply && hi_hit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_tok_q  <= '0;
			hi_tok_q  <= '0;
			hi_last_q <= '0;
			upd_h1    <= 1'b0;
			upd_h2    <= 1'b0;
			upd_h3    <= 1'b0;
		end else begin
			if (adv && v_s4) begin
				lo_tok_q <= lo_nxt;
				hi_tok_q <= hi_nxt;
				if (upd_now)
					hi_last_q <= ts_s4;
			end else begin
				// levels stay within depth; this only bites after a rate change
				lo_tok_q <= clamp_lvl(SUM_W'(lo_tok_q), lo_depth_q);
				hi_tok_q <= clamp_lvl(SUM_W'(hi_tok_q), hi_depth_q);
			end
			if (adv) begin
				upd_h1 <= upd_now;
				upd_h2 <= upd_h1;
				upd_h3 <= upd_h2;
			end
		end
	end

	// ---------------------------------------------------------------- output
	logic                    res_valid_q, accept_q;
	dtba_pkg::pool_t         pool_q;
	logic signed [LVL_W-1:0] lo_lvl_q, hi_lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv && v_s4)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			accept_q <= acc_nxt;
			pool_q   <= pool_nxt;
			lo_lvl_q <= lo_nxt;
			hi_lvl_q <= hi_nxt;
		end
	end

	assign res_valid    = res_valid_q;
	assign accept       = accept_q;
	assign charged_pool = pool_q;
	assign low_level    = lo_lvl_q;
	assign high_level   = hi_lvl_q;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Checks the two-pool token bucket admission block beat by beat against a
// predictor kept in step with every configuration write and packet beat.
module testbench;
	import dtba_pkg::*;

	localparam int REFILL_SHIFT      = REFILL_SHIFT_DEF;
	localparam int BUCKET_SECONDS    = BUCKET_SECONDS_DEF;
	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int CFG_SETTLE_CYCLES = 6;
	localparam int END_CYCLES        = 12;
	localparam int MAX_REPORTS       = 10;
	localparam int ITEMS_PER_PHASE   = 62;
	localparam int PHASES_PER_MODE   = 3;
	localparam int FIRST_SPARE_REG   = REG_LOW_UNLIM + 1;
	localparam int RATE_FIELD_MAX    = (1 << CFG_DATA_W) - 1;
	localparam int LOW_B             = 0;
	localparam int HIGH_B            = 1;

	// One token bucket as the predictor sees it
	typedef struct {
		longint unsigned rate;     // bytes per second
		longint          depth;
		longint          tokens;
		longint unsigned last;     // time of the last refill
	} bucket_t;

	// What one packet beat should produce on the result channel
	typedef struct {
		logic                     accept;
		pool_t                    pool;
		logic signed [LVL_W-1:0]  low_level;
		logic signed [LVL_W-1:0]  high_level;
	} admission_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  pkt_valid = 1'b0;
	logic                  pkt_ready;
	logic [TS_W-1:0]       timestamp_ns = '0;
	logic [LEN_W-1:0]      packet_length = '0;
	logic                  high_priority = 1'b0;
	logic                  in_class = 1'b0;

	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic                  accept;
	logic [1:0]            charged_pool;
	logic signed [LVL_W-1:0] low_level;
	logic signed [LVL_W-1:0] high_level;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: registers and both buckets
	longint unsigned guar_mbps;
	longint unsigned ceil_mbps;
	logic            high_unlim;
	logic            low_unlim;
	logic            restart_pending;
	bucket_t         bucket [2];

	admission_t      expected_q [$];
	longint unsigned now_ns;
	int unsigned     send_idle_pct = 0;
	int unsigned     stall_pct = 0;
	int unsigned     mismatches = 0;
	int unsigned     results_seen = 0;
	int unsigned     quiet_cycles = 0;

	dual_token_bucket_admission_top #(
		.REFILL_SHIFT   (REFILL_SHIFT),
		.BUCKET_SECONDS (BUCKET_SECONDS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pkt_valid     (pkt_valid),
		.pkt_ready     (pkt_ready),
		.timestamp_ns  (timestamp_ns),
		.packet_length (packet_length),
		.high_priority (high_priority),
		.in_class      (in_class),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.accept        (accept),
		.charged_pool  (charged_pool),
		.low_level     (low_level),
		.high_level    (high_level),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// Hold the level within plus and minus the depth
	function automatic void clamp_bucket(int b);
		if (bucket[b].tokens > bucket[b].depth)
			bucket[b].tokens = bucket[b].depth;
		if (bucket[b].tokens < -bucket[b].depth)
			bucket[b].tokens = -bucket[b].depth;
	endfunction

	// Mbit/s to bytes/s is an exact multiply by 125000; depth is the bucket
	// span worth of bytes, saturated so that levels fit the level width
	function automatic void set_bucket_rate(int b, longint unsigned mbps);
		longint unsigned d;
		bucket[b].rate = mbps * BYTES_PER_MBPS;
		d = BUCKET_SECONDS * bucket[b].rate;
		bucket[b].depth = (d > DEPTH_CAP) ? longint'(DEPTH_CAP) : longint'(d);
		clamp_bucket(b);
	endfunction

	// High pool takes whatever the ceiling leaves above the guarantee
	function automatic void apply_rates();
		longint unsigned hi;
		hi = (ceil_mbps > guar_mbps) ? ceil_mbps - guar_mbps : 64'd0;
		set_bucket_rate(HIGH_B, hi);
		set_bucket_rate(LOW_B, guar_mbps);
	endfunction

	function automatic void model_config_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		longint unsigned v;
		v = (data > RATE_CAP) ? RATE_CAP : longint'(data);
		case (idx)
			REG_GUARANTEED: begin
				if (v != guar_mbps) begin
					guar_mbps = v;
					apply_rates();
					restart_pending = 1'b1;
				end
			end
			REG_CEILING: begin
				if (v != ceil_mbps) begin
					ceil_mbps = v;
					apply_rates();
					restart_pending = 1'b1;
				end
			end
			REG_HIGH_UNLIM: high_unlim = data[0];
			REG_LOW_UNLIM:  low_unlim = data[0];
			default: ;
		endcase
	endfunction

	// Refill only once more than span >> REFILL_SHIFT has passed; a negative
	// elapsed time (as signed) leaves level and refill time alone
	function automatic longint refill_bucket(int b, longint unsigned now);
		longint unsigned span;
		longint unsigned el;
		longint unsigned add;
		span = BUCKET_SECONDS * NS_PER_S;
		el = now - bucket[b].last;
		if (!el[63] && el > (span >> REFILL_SHIFT)) begin
			bucket[b].last = now;
			if (el > span)
				el = span;
			add = bucket[b].rate * (el / NS_PER_S)
				+ (bucket[b].rate * (el % NS_PER_S)) / NS_PER_S;
			bucket[b].tokens += $signed(add);
			clamp_bucket(b);
		end
		return bucket[b].tokens;
	endfunction

	function automatic admission_t predict_admission(longint unsigned now,
			logic [LEN_W-1:0] len_bytes, logic hp, logic ic);
		admission_t r;
		longint len;
		longint h;
		longint room;
		len = len_bytes;
		r.accept = 1'b1;
		r.pool = POOL_NONE;
		if (restart_pending) begin
			bucket[LOW_B].last = now;
			bucket[HIGH_B].last = now;
			restart_pending = 1'b0;
		end
		if (ic && len <= bucket[LOW_B].depth) begin
			if (hp) begin
				if (!high_unlim) begin
					if (refill_bucket(LOW_B, now) > len) begin
						bucket[LOW_B].tokens -= len;
						r.pool = POOL_LOW;
					end else begin
						h = refill_bucket(HIGH_B, now);
						if (h > len) begin
							bucket[HIGH_B].tokens -= len;
							r.pool = POOL_HIGH;
						end else begin
							// debt never goes below minus depth
							room = h + bucket[HIGH_B].depth;
							bucket[HIGH_B].tokens -= (room < len) ? room : len;
							r.pool = POOL_DEBT;
						end
					end
				end
			end else if (!low_unlim) begin
				h = refill_bucket(HIGH_B, now);
				void'(refill_bucket(LOW_B, now));
				if (h > len) begin
					bucket[HIGH_B].tokens -= len;
					r.pool = POOL_HIGH;
				end else if (bucket[LOW_B].tokens + bucket[LOW_B].depth > len) begin
					bucket[LOW_B].tokens -= len;
					r.pool = POOL_LOW;
				end else begin
					r.accept = 1'b0;
				end
			end
		end
		r.low_level = bucket[LOW_B].tokens[LVL_W-1:0];
		r.high_level = bucket[HIGH_B].tokens[LVL_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Channel drivers, all driven at the falling edge
	// ---------------------------------------------------------------

	// Send one packet beat. Returns at a falling edge with valid still high so
	// that back-to-back beats need no bubble.
	task automatic send_packet(input longint unsigned ts, input logic [LEN_W-1:0] len,
			input logic hp, input logic ic);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			pkt_valid <= 1'b0;
			@(negedge clk);
		end
		pkt_valid <= 1'b1;
		timestamp_ns <= ts;
		packet_length <= len;
		high_priority <= hp;
		in_class <= ic;
		do @(posedge clk); while (!pkt_ready);
		expected_q.push_back(predict_admission(ts, len, hp, ic));
		@(negedge clk);
	endtask

	// Drop valid and hold until every outstanding result beat has come back
	task automatic wait_for_results();
		pkt_valid <= 1'b0;
		do @(negedge clk); while (expected_q.size() != 0);
	endtask

	task automatic settle_for_config();
		wait_for_results();
		repeat (CFG_SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write; only ever called with the block idle
	task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		model_config_write(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Result side: stall at random according to the current mode
	always @(negedge clk)
		res_ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------

	task automatic log_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: result %0d %s: expected %0d, got %0d",
				$realtime, results_seen, what, want, got);
	endtask

	always @(posedge clk) begin
		admission_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_q.size() == 0) begin
				log_mismatch("beat with no packet outstanding", 0, 1);
			end else begin
				want = expected_q.pop_front();
				if (accept !== want.accept)
					log_mismatch("accept", want.accept, accept);
				if (charged_pool !== want.pool)
					log_mismatch("charged_pool", want.pool, charged_pool);
				if (low_level !== want.low_level)
					log_mismatch("low_level", want.low_level, low_level);
				if (high_level !== want.high_level)
					log_mismatch("high_level", want.high_level, high_level);
			end
			results_seen++;
		end
	end

	// Watchdog: end the run if no channel moves a beat for too long
	always @(posedge clk) begin
		if ((pkt_valid && pkt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Default rates leave the low pool with zero depth, so any non-empty packet
	// in class is an oversize bypass; zero-length ones reach the pools.
	task automatic test_after_reset();
		now_ns = 0;
		// first beat restarts both refill clocks; zero length lands in debt
		send_packet(now_ns, 0, 1'b1, 1'b1);
		send_packet(now_ns, '1, 1'b0, 1'b1);      // oversize bypass
		send_packet(now_ns, '1, 1'b1, 1'b0);      // not in class
		send_packet(now_ns, 0, 1'b0, 1'b1);       // nothing to borrow: drop
	endtask

	task automatic test_pool_charging();
		settle_for_config();
		write_register(REG_GUARANTEED, 10);
		write_register(REG_CEILING, '1);          // above range, saturates
		write_register(cfg_index_t'(FIRST_SPARE_REG), '1);
		write_register('1, '1);
		now_ns = 64'd1_000_000_000;
		send_packet(now_ns, 1500, 1'b1, 1'b1);    // both pools empty: debt
		now_ns += 64'd2_000_000_000;              // elapsed beyond the span
		send_packet(now_ns, '1, 1'b1, 1'b1);      // low pool
		now_ns += 64'd20_000_000;
		send_packet(now_ns, '1, 1'b0, 1'b1);      // high pool
		send_packet(now_ns, 40, 1'b1, 1'b1);
	endtask

	task automatic test_borrow_and_drop();
		settle_for_config();
		write_register(REG_GUARANTEED, 1);
		write_register(REG_CEILING, 1);           // high pool depth zero
		now_ns += 64'd1_000_000_000;
		// borrow the low pool down towards minus depth, then drop
		repeat (4) send_packet(now_ns, '1, 1'b0, 1'b1);
		send_packet(now_ns, '1, 1'b1, 1'b1);      // debt with no room
		send_packet(now_ns - 64'd500_000_000, 100, 1'b0, 1'b1);  // time going back
		// rewriting the same value must not restart the refill clocks
		settle_for_config();
		write_register(REG_CEILING, 1);
		now_ns += 64'd20_000_000;
		send_packet(now_ns, 1500, 1'b0, 1'b1);
		now_ns = '1;
		send_packet(now_ns, 1500, 1'b1, 1'b1);
		// guarantee above ceiling leaves the high pool with no rate
		settle_for_config();
		write_register(REG_GUARANTEED, 50);
		send_packet(now_ns, 1500, 1'b0, 1'b1);
	endtask

	task automatic test_unlimited_bypass();
		settle_for_config();
		write_register(REG_HIGH_UNLIM, '1);
		write_register(REG_LOW_UNLIM, 1);
		send_packet(now_ns, 9000, 1'b1, 1'b1);
		send_packet(now_ns, 9000, 1'b0, 1'b1);
		settle_for_config();
		// only bit 0 counts
		write_register(REG_HIGH_UNLIM, 17'h1FFFE);
		write_register(REG_LOW_UNLIM, 0);
		send_packet(now_ns, 9000, 1'b1, 1'b1);
	endtask

	// Small rates keep pools near empty so that borrowing, debt and drops
	// turn up often; the extremes and out-of-range values appear too.
	function automatic logic [CFG_DATA_W-1:0] pick_rate();
		case ($urandom_range(7))
			0: return 0;
			1: return RATE_CAP;
			2: return $urandom_range(RATE_FIELD_MAX, RATE_CAP + 1);
			3: return $urandom_range(5, 1);
			4, 5: return $urandom_range(100, 1);
			default: return $urandom_range(RATE_FIELD_MAX, 0);
		endcase
	endfunction

	task automatic test_random_traffic(input int unsigned tx_idle, input int unsigned rx_stall);
		int unsigned phase;
		int unsigned n;
		logic [CFG_DATA_W-1:0] flag_word;
		logic [LEN_W-1:0] len;
		send_idle_pct = tx_idle;
		stall_pct = rx_stall;
		for (phase = 0; phase < PHASES_PER_MODE; phase++) begin
			settle_for_config();
			write_register(REG_GUARANTEED, pick_rate());
			write_register(REG_CEILING, pick_rate());
			flag_word = $urandom;
			flag_word[0] = ($urandom_range(3) == 0);
			write_register(REG_HIGH_UNLIM, flag_word);
			flag_word = $urandom;
			flag_word[0] = ($urandom_range(3) == 0);
			write_register(REG_LOW_UNLIM, flag_word);
			if ($urandom_range(3) == 0)
				write_register(cfg_index_t'($urandom_range(255, FIRST_SPARE_REG)), $urandom);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// in the first phase, hold off mid-phase until the pipe has fully drained
				if (phase == 0 && n == ITEMS_PER_PHASE / 2)
					wait_for_results();
				case ($urandom_range(19))
					0: now_ns = {$urandom, $urandom};
					1: now_ns -= $urandom_range(50_000_000);
					2: now_ns += 64'd1_000_000_000 + $urandom_range(2_000_000_000);
					3, 4: ;
					default: now_ns += $urandom_range(40_000_000);
				endcase
				case ($urandom_range(7))
					0: len = 0;
					1: len = '1;
					2, 3: len = $urandom_range(65535);
					default: len = $urandom_range(1500, 40);
				endcase
				send_packet(now_ns, len, $urandom_range(1), $urandom_range(9) != 0);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		guar_mbps = 0;
		ceil_mbps = 1000;
		high_unlim = 1'b0;
		low_unlim = 1'b0;
		bucket[LOW_B] = '{rate: 0, depth: 0, tokens: 0, last: 0};
		bucket[HIGH_B] = '{rate: 0, depth: 0, tokens: 0, last: 0};
		apply_rates();
		restart_pending = 1'b1;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_after_reset();
		test_pool_charging();
		test_borrow_and_drop();
		test_unlimited_bypass();
		test_random_traffic(0, 0);
		test_random_traffic(69, 0);
		test_random_traffic(0, 69);
		test_random_traffic(37, 37);

		// drain, then keep the result side open for any stray beat to show up
		wait_for_results();
		stall_pct = 0;
		repeat (END_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
